[hw/rtl/wgd_pkg.sv]
package wgd_pkg;

    localparam int ACCEL_W = 13;

    // storage depth of the queue between classifier and state engine
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] DEF_TIMEOUT_TICKS    = 16'd0;
    localparam logic [3:0]  DEF_ACTIVE_THRESHOLD = 4'd5;
    localparam logic [5:0]  DEF_DOWNWARD_WINDOW  = 6'd14;
    localparam logic [5:0]  DEF_AWAY_WINDOW      = 6'd12;

    localparam logic [3:0]  RUN_MAX    = 4'd15;
    localparam logic [5:0]  WINDOW_MAX = 6'd63;

    // box bounds, inclusive
    localparam logic signed [ACCEL_W-1:0] ACT_X_LO  = -13'sd500;
    localparam logic signed [ACCEL_W-1:0] ACT_X_HI  =  13'sd500;
    localparam logic signed [ACCEL_W-1:0] ACT_Y_LO  = -13'sd1100;
    localparam logic signed [ACCEL_W-1:0] ACT_Y_HI  = -13'sd200;
    localparam logic signed [ACCEL_W-1:0] ACT_Z_LO  = -13'sd1100;
    localparam logic signed [ACCEL_W-1:0] ACT_Z_HI  =  13'sd350;

    localparam logic signed [ACCEL_W-1:0] DNL_X_LO  =  13'sd800;
    localparam logic signed [ACCEL_W-1:0] DNL_X_HI  =  13'sd1000;
    localparam logic signed [ACCEL_W-1:0] DNR_X_LO  = -13'sd1000;
    localparam logic signed [ACCEL_W-1:0] DNR_X_HI  = -13'sd800;
    localparam logic signed [ACCEL_W-1:0] DN_Y_LO   = -13'sd500;
    localparam logic signed [ACCEL_W-1:0] DN_Y_HI   =  13'sd500;
    localparam logic signed [ACCEL_W-1:0] DN_Z_LO   = -13'sd800;
    localparam logic signed [ACCEL_W-1:0] DN_Z_HI   =  13'sd800;

    localparam logic signed [ACCEL_W-1:0] AWAY_X_LO = -13'sd600;
    localparam logic signed [ACCEL_W-1:0] AWAY_X_HI =  13'sd600;
    localparam logic signed [ACCEL_W-1:0] AWAY_Y_LO =  13'sd700;
    localparam logic signed [ACCEL_W-1:0] AWAY_Y_HI =  13'sd1200;
    localparam logic signed [ACCEL_W-1:0] AWAY_Z_LO = -13'sd500;
    localparam logic signed [ACCEL_W-1:0] AWAY_Z_HI =  13'sd500;

    typedef enum logic [2:0] {
        CLS_TICK   = 3'd0,
        CLS_ACTIVE = 3'd1,
        CLS_DOWN   = 3'd2,
        CLS_AWAY   = 3'd3,
        CLS_DEAD   = 3'd4
    } item_class_t;

    typedef enum logic [1:0] {
        GS_INACTIVE = 2'd0,
        GS_ACTIVE   = 2'd1,
        GS_TIMEDOUT = 2'd2
    } glance_state_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT_TICKS    = 2'd0,
        CFG_ACTIVE_THRESHOLD = 2'd1,
        CFG_DOWNWARD_WINDOW  = 2'd2,
        CFG_AWAY_WINDOW      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [3:0]  active_threshold;
        logic [5:0]  downward_window;
        logic [5:0]  away_window;
    } cfg_t;

    function automatic logic in_range(
        input logic signed [ACCEL_W-1:0] v,
        input logic signed [ACCEL_W-1:0] lo,
        input logic signed [ACCEL_W-1:0] hi
    );
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

[hw/rtl/wgd_front.sv]
module wgd_front (
    input  logic                              func,
    input  logic signed [wgd_pkg::ACCEL_W-1:0] accel_x,
    input  logic signed [wgd_pkg::ACCEL_W-1:0] accel_y,
    input  logic signed [wgd_pkg::ACCEL_W-1:0] accel_z,
    output wgd_pkg::item_class_t              item_class
);

    logic hit_active;
    logic hit_down_left;
    logic hit_down_right;
    logic hit_away;

    assign hit_active = wgd_pkg::in_range(accel_x, wgd_pkg::ACT_X_LO, wgd_pkg::ACT_X_HI)
                     && wgd_pkg::in_range(accel_y, wgd_pkg::ACT_Y_LO, wgd_pkg::ACT_Y_HI)
                     && wgd_pkg::in_range(accel_z, wgd_pkg::ACT_Z_LO, wgd_pkg::ACT_Z_HI);

    assign hit_down_left = wgd_pkg::in_range(accel_x, wgd_pkg::DNL_X_LO, wgd_pkg::DNL_X_HI)
                        && wgd_pkg::in_range(accel_y, wgd_pkg::DN_Y_LO, wgd_pkg::DN_Y_HI)
                        && wgd_pkg::in_range(accel_z, wgd_pkg::DN_Z_LO, wgd_pkg::DN_Z_HI);

    assign hit_down_right = wgd_pkg::in_range(accel_x, wgd_pkg::DNR_X_LO, wgd_pkg::DNR_X_HI)
                         && wgd_pkg::in_range(accel_y, wgd_pkg::DN_Y_LO, wgd_pkg::DN_Y_HI)
                         && wgd_pkg::in_range(accel_z, wgd_pkg::DN_Z_LO, wgd_pkg::DN_Z_HI);

    assign hit_away = wgd_pkg::in_range(accel_x, wgd_pkg::AWAY_X_LO, wgd_pkg::AWAY_X_HI)
                   && wgd_pkg::in_range(accel_y, wgd_pkg::AWAY_Y_LO, wgd_pkg::AWAY_Y_HI)
                   && wgd_pkg::in_range(accel_z, wgd_pkg::AWAY_Z_LO, wgd_pkg::AWAY_Z_HI);

    // active box wins over the others
    always_comb
    begin
        priority if (func)
            item_class = wgd_pkg::CLS_TICK;
        else if (hit_active)
            item_class = wgd_pkg::CLS_ACTIVE;
        else if (hit_down_left || hit_down_right)
            item_class = wgd_pkg::CLS_DOWN;
        else if (hit_away)
            item_class = wgd_pkg::CLS_AWAY;
        else
            item_class = wgd_pkg::CLS_DEAD;
    end

endmodule

[hw/rtl/wgd_queue.sv]
module wgd_queue #(
    parameter int DEPTH = wgd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wgd_pkg::item_class_t in_class,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wgd_pkg::item_class_t out_class
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wgd_pkg::item_class_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_class = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_class;
    end

endmodule

[hw/rtl/wgd_back.sv]
module wgd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wgd_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  wgd_pkg::item_class_t q_class,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           glance_state,
    output logic                 state_changed
);

    wgd_pkg::glance_state_t state_reg, state_next;
    logic        rearmed_reg, rearmed_next;
    logic [3:0]  run_reg, run_next;
    logic [5:0]  window_reg, window_next;
    logic [15:0] tleft_reg, tleft_next;
    logic        tarmed_reg, tarmed_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  glance_state_reg, glance_state_next;
    logic        state_changed_reg, state_changed_next;

    logic        pop;

    // output register frees up when empty or being taken
    assign q_ready = !out_valid_reg || out_ready;
    assign pop     = q_valid && q_ready;

    // state update for the transaction at the queue head
    always_comb
    begin
        logic [3:0]  run_inc;
        logic [15:0] tdec;
        logic [5:0]  win_load;

        run_inc  = (run_reg == wgd_pkg::RUN_MAX) ? run_reg : run_reg + 4'd1;
        tdec     = (tleft_reg != '0) ? tleft_reg - 16'd1 : tleft_reg;
        win_load = '0;

        state_next   = state_reg;
        rearmed_next = rearmed_reg;
        run_next     = run_reg;
        window_next  = window_reg;
        tleft_next   = tleft_reg;
        tarmed_next  = tarmed_reg;

        if (pop)
        begin
            unique case (q_class)
                wgd_pkg::CLS_TICK:
                begin
                    if (tarmed_reg)
                    begin
                        tleft_next = tdec;
                        if (tdec == '0)
                        begin
                            tarmed_next = 1'b0;
                            state_next  = wgd_pkg::GS_TIMEDOUT;
                        end
                    end
                end
                wgd_pkg::CLS_ACTIVE:
                begin
                    run_next = run_inc;
                    if (rearmed_reg && (run_inc >= cfg.active_threshold)
                        && (window_reg != '0))
                    begin
                        rearmed_next = 1'b0;
                        state_next   = wgd_pkg::GS_ACTIVE;
                        if (cfg.timeout_ticks != '0)
                        begin
                            tleft_next  = cfg.timeout_ticks;
                            tarmed_next = 1'b1;
                        end
                    end
                end
                wgd_pkg::CLS_DOWN,
                wgd_pkg::CLS_AWAY:
                begin
                    win_load = (q_class == wgd_pkg::CLS_DOWN) ?
                               cfg.downward_window : cfg.away_window;
                    rearmed_next = 1'b1;
                    run_next     = '0;
                    window_next  = (win_load == wgd_pkg::WINDOW_MAX) ?
                                   wgd_pkg::WINDOW_MAX : win_load + 6'd1;
                    state_next   = wgd_pkg::GS_INACTIVE;
                    tarmed_next  = 1'b0;
                    tleft_next   = '0;
                end
                default:
                begin
                    run_next = '0;
                end
            endcase

            // window ages by one per sample
            if ((q_class != wgd_pkg::CLS_TICK) && (window_next != '0))
                window_next = window_next - 6'd1;
        end
    end

    always_comb
    begin
        out_valid_next     = out_valid_reg;
        glance_state_next  = glance_state_reg;
        state_changed_next = state_changed_reg;
        if (pop)
        begin
            out_valid_next     = 1'b1;
            glance_state_next  = state_next;
            state_changed_next = (state_next != state_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wgd_pkg::GS_INACTIVE;
            rearmed_reg   <= 1'b1;
            run_reg       <= '0;
            window_reg    <= '0;
            tleft_reg     <= '0;
            tarmed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rearmed_reg   <= rearmed_next;
            run_reg       <= run_next;
            window_reg    <= window_next;
            tleft_reg     <= tleft_next;
            tarmed_reg    <= tarmed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glance_state_reg  <= glance_state_next;
        state_changed_reg <= state_changed_next;
    end

    assign out_valid     = out_valid_reg;
    assign glance_state  = glance_state_reg;
    assign state_changed = state_changed_reg;

    a_timeout_only_when_active: assert property (@(posedge clk) disable iff (!rst_n)
        tarmed_reg |-> (state_reg == wgd_pkg::GS_ACTIVE))
        else $error("timeout running outside active state");

    a_inactive_is_rearmed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wgd_pkg::GS_INACTIVE) |-> rearmed_reg)
        else $error("inactive state without rearm");

    a_pose_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && ((q_class == wgd_pkg::CLS_DOWN) || (q_class == wgd_pkg::CLS_AWAY)))
        |=> (rearmed_reg && (run_reg == '0) && !tarmed_reg))
        else $error("inactive pose did not reset the run");

    a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && (glance_state_reg == state_reg)))
        else $error("popped transaction did not reach the output register");

endmodule

[hw/rtl/wrist_glance_detector_core.sv]
// Wrist glance detector. Each transaction is an accelerometer sample
// (func = 0) or a timer tick (func = 1) and yields exactly one result
// carrying the glance state and a changed flag. One transaction per clock
// is sustained while out_ready stays high; the box classifier writes the
// class into the queue when the transaction is accepted, and the state
// update fills the output register from the queue head. The queue of
// QUEUE_DEPTH entries lets input keep flowing while the output side stalls.
// Configuration writes take effect on the next clock and must only be
// issued while idle.
module wrist_glance_detector_core #(
    parameter int QUEUE_DEPTH = wgd_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic signed [wgd_pkg::ACCEL_W-1:0] accel_x,
    input  logic signed [wgd_pkg::ACCEL_W-1:0] accel_y,
    input  logic signed [wgd_pkg::ACCEL_W-1:0] accel_z,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        glance_state,
    output logic                              state_changed
);

    wgd_pkg::cfg_t        cfg_reg;
    wgd_pkg::item_class_t front_class;
    wgd_pkg::item_class_t q_class;
    logic                 q_valid;
    logic                 q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks    <= wgd_pkg::DEF_TIMEOUT_TICKS;
            cfg_reg.active_threshold <= wgd_pkg::DEF_ACTIVE_THRESHOLD;
            cfg_reg.downward_window  <= wgd_pkg::DEF_DOWNWARD_WINDOW;
            cfg_reg.away_window      <= wgd_pkg::DEF_AWAY_WINDOW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wgd_pkg::CFG_TIMEOUT_TICKS:    cfg_reg.timeout_ticks    <= cfg_data;
                wgd_pkg::CFG_ACTIVE_THRESHOLD: cfg_reg.active_threshold <= cfg_data[3:0];
                wgd_pkg::CFG_DOWNWARD_WINDOW:  cfg_reg.downward_window  <= cfg_data[5:0];
                wgd_pkg::CFG_AWAY_WINDOW:      cfg_reg.away_window      <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    wgd_front u_front (
        .func       (func),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .item_class (front_class)
    );

    wgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_class  (front_class),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_class (q_class)
    );

    wgd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_class       (q_class),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .glance_state  (glance_state),
        .state_changed (state_changed)
    );

endmodule

[dv/glance_tracker.sv]
module glance_tracker
    import wgd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                func,
    input  logic signed [12:0]  accel_x,
    input  logic signed [12:0]  accel_y,
    input  logic signed [12:0]  accel_z,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          glance_state,
    input  logic                state_changed,
    output int                  mismatches,
    output int                  outstanding
);

    typedef struct packed {
        glance_state_t state;
        logic          changed;
    } glance_result_t;

    cfg_t          cfg;
    glance_state_t cur_state;
    logic          rearmed;
    logic [3:0]    run_len;
    logic [5:0]    window_left;
    logic [15:0]   timeout_left;
    logic          timeout_armed;

    glance_result_t expected_glances[$];
    int mismatch_total = 0;
    int results_seen = 0;

    assign mismatches = mismatch_total;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s, got %0d expected %0d",
                 results_seen, what, got, want);
        mismatch_total++;
    endtask

    function automatic logic between(input int v, input int lo, input int hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [5:0] load_window(input logic [5:0] w);
        logic [6:0] v;
        v = {1'b0, w} + 7'd1;
        return (v > 7'd63) ? 6'd63 : v[5:0];
    endfunction

    task automatic enter_rest_pose(input logic [5:0] w);
        rearmed       = 1'b1;
        run_len       = 4'd0;
        window_left   = load_window(w);
        cur_state     = GS_INACTIVE;
        timeout_armed = 1'b0;
        timeout_left  = 16'd0;
    endtask

    task automatic predict_glance(input logic f, input logic signed [12:0] ax,
                                  input logic signed [12:0] ay,
                                  input logic signed [12:0] az,
                                  output glance_result_t r);
        glance_state_t prior;
        int x, y, z;
        prior = cur_state;
        x = ax;
        y = ay;
        z = az;
        if (f) begin
            if (timeout_armed) begin
                if (timeout_left != 16'd0)
                    timeout_left = timeout_left - 16'd1;
                if (timeout_left == 16'd0) begin
                    timeout_armed = 1'b0;
                    cur_state     = GS_TIMEDOUT;
                end
            end
        end
        else begin
            // active box has priority, then both downward boxes, then away
            if (between(x, -500, 500) && between(y, -1100, -200) && between(z, -1100, 350)) begin
                if (run_len != 4'd15)
                    run_len = run_len + 4'd1;
                if (rearmed && run_len >= cfg.active_threshold && window_left != 6'd0) begin
                    rearmed   = 1'b0;
                    cur_state = GS_ACTIVE;
                    if (cfg.timeout_ticks != 16'd0) begin
                        timeout_left  = cfg.timeout_ticks;
                        timeout_armed = 1'b1;
                    end
                end
            end
            else if ((between(x, 800, 1000) || between(x, -1000, -800)) &&
                     between(y, -500, 500) && between(z, -800, 800))
                enter_rest_pose(cfg.downward_window);
            else if (between(x, -600, 600) && between(y, 700, 1200) && between(z, -500, 500))
                enter_rest_pose(cfg.away_window);
            else
                run_len = 4'd0;
            if (window_left != 6'd0)
                window_left = window_left - 6'd1;
        end
        r.state   = cur_state;
        r.changed = (cur_state != prior);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        glance_result_t want;
        if (!rst_n)
        begin
            cfg.timeout_ticks    = 16'd0;
            cfg.active_threshold = 4'd5;
            cfg.downward_window  = 6'd14;
            cfg.away_window      = 6'd12;
            cur_state     = GS_INACTIVE;
            rearmed       = 1'b1;
            run_len       = 4'd0;
            window_left   = 6'd0;
            timeout_left  = 16'd0;
            timeout_armed = 1'b0;
            expected_glances.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_glances.size() == 0)
                    report_mismatch("result with no transaction pending", glance_state, -1);
                else
                begin
                    want = expected_glances.pop_front();
                    if (glance_state != want.state)
                        report_mismatch("glance_state", glance_state, want.state);
                    if (state_changed != want.changed)
                        report_mismatch("state_changed", state_changed, want.changed);
                end
                results_seen++;
            end
            if (in_valid && in_ready)
            begin
                predict_glance(func, accel_x, accel_y, accel_z, want);
                expected_glances.push_back(want);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIMEOUT_TICKS:    cfg.timeout_ticks    = cfg_data;
                    CFG_ACTIVE_THRESHOLD: cfg.active_threshold = cfg_data[3:0];
                    CFG_DOWNWARD_WINDOW:  cfg.downward_window  = cfg_data[5:0];
                    CFG_AWAY_WINDOW:      cfg.away_window      = cfg_data[5:0];
                    default: ;
                endcase
            end
            outstanding <= expected_glances.size();
        end
    end

endmodule

[dv/testbench.sv]
module testbench;
    import wgd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int RANDOM_ITEMS   = 900;
    localparam int PHASES         = 8;

    typedef enum int {
        P_ACTIVE,
        P_DOWN_L,
        P_DOWN_R,
        P_AWAY,
        P_DEAD,
        P_NOISE,
        P_EDGE
    } pose_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = 2'd0;
    logic [15:0]        cfg_data = 16'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = 1'b0;
    logic signed [12:0] accel_x = 13'sd0;
    logic signed [12:0] accel_y = 13'sd0;
    logic signed [12:0] accel_z = 13'sd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         glance_state;
    logic               state_changed;

    int mismatches;
    int outstanding;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_request = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int glances_seen = 0;
    int timeouts_seen = 0;
    logic [15:0] timeout_setting = 16'd0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wrist_glance_detector_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .glance_state(glance_state), .state_changed(state_changed)
    );

    glance_tracker TRACKER (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .glance_state(glance_state), .state_changed(state_changed),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request != hold_served)
        begin
            hold_served <= hold_request;
            hold_left   <= LONG_HOLD;
            out_ready   <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready && state_changed)
            begin
                if (glance_state == GS_ACTIVE)
                    glances_seen <= glances_seen + 1;
                if (glance_state == GS_TIMEDOUT)
                    timeouts_seen <= timeouts_seen + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic void box_span(input int b, input int a, output int lo, output int hi);
        case (b * 3 + a)
            0:  begin lo = ACT_X_LO;  hi = ACT_X_HI;  end
            1:  begin lo = ACT_Y_LO;  hi = ACT_Y_HI;  end
            2:  begin lo = ACT_Z_LO;  hi = ACT_Z_HI;  end
            3:  begin lo = DNL_X_LO;  hi = DNL_X_HI;  end
            4:  begin lo = DN_Y_LO;   hi = DN_Y_HI;   end
            5:  begin lo = DN_Z_LO;   hi = DN_Z_HI;   end
            6:  begin lo = DNR_X_LO;  hi = DNR_X_HI;  end
            7:  begin lo = DN_Y_LO;   hi = DN_Y_HI;   end
            8:  begin lo = DN_Z_LO;   hi = DN_Z_HI;   end
            9:  begin lo = AWAY_X_LO; hi = AWAY_X_HI; end
            10: begin lo = AWAY_Y_LO; hi = AWAY_Y_HI; end
            default: begin lo = AWAY_Z_LO; hi = AWAY_Z_HI; end
        endcase
    endfunction

    task automatic send_item(input logic f, input int x, input int y, input int z);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        accel_x  <= 13'(x);
        accel_y  <= 13'(y);
        accel_z  <= 13'(z);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // ticks carry junk in the acceleration fields
    task automatic send_tick();
        send_item(1'b1, rand_between(-4096, 4095), rand_between(-4096, 4095),
                  rand_between(-4096, 4095));
    endtask

    task automatic send_pose(input pose_t p);
        int b, a, lo, hi;
        int c[3];
        if (p == P_DOWN_L)
            b = 1;
        else if (p == P_DOWN_R)
            b = 2;
        else if (p == P_AWAY)
            b = 3;
        else if (p == P_EDGE)
            b = $urandom_range(3);
        else
            b = 0;
        for (a = 0; a < 3; a++)
        begin
            box_span(b, a, lo, hi);
            c[a] = rand_between(lo, hi);
        end
        if (p == P_EDGE)
        begin
            // one axis on or just past a box bound
            a = $urandom_range(2);
            box_span(b, a, lo, hi);
            case ($urandom_range(3))
                0: c[a] = lo - 1;
                1: c[a] = lo;
                2: c[a] = hi;
                default: c[a] = hi + 1;
            endcase
        end
        else if (p == P_DEAD)
        begin
            if ($urandom_range(1))
            begin
                c[0] = $urandom_range(1) ? rand_between(1001, 4095) : rand_between(-4096, -1001);
                c[1] = rand_between(-4096, 4095);
                c[2] = rand_between(-4096, 4095);
            end
            else
            begin
                c[0] = rand_between(-500, 500);
                c[1] = rand_between(-199, 699);
                c[2] = rand_between(-4096, 4095);
            end
        end
        else if (p == P_NOISE)
        begin
            for (a = 0; a < 3; a++)
                c[a] = rand_between(-4096, 4095);
        end
        send_item(1'b0, c[0], c[1], c[2]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] t, input logic [3:0] th,
                             input logic [5:0] dw, input logic [5:0] aw);
        drain();
        write_reg(CFG_TIMEOUT_TICKS, t);
        write_reg(CFG_ACTIVE_THRESHOLD, {12'($urandom), th});
        write_reg(CFG_DOWNWARD_WINDOW, {10'($urandom), dw});
        write_reg(CFG_AWAY_WINDOW, {10'($urandom), aw});
        cfg_we <= 1'b0;
        timeout_setting = t;
    endtask

    // rest pose, short pause, a run of active samples, then ticks
    task automatic run_gesture();
        int n, k;
        pose_t rest;
        k = $urandom_range(2);
        rest = (k == 0) ? P_DOWN_L : (k == 1) ? P_DOWN_R : P_AWAY;
        n = $urandom_range(3, 1);
        repeat (n) send_pose(rest);
        n = $urandom_range(3);
        repeat (n)
            if ($urandom_range(1))
                send_pose(P_DEAD);
            else
                send_tick();
        n = $urandom_range(17);
        repeat (n)
            if ($urandom_range(19) == 0)
                send_pose(P_DEAD);
            else
                send_pose(P_ACTIVE);
        n = $urandom_range(timeout_setting > 20 ? 24 : timeout_setting + 3);
        repeat (n)
            if ($urandom_range(9) == 0)
                send_pose(P_ACTIVE);
            else
                send_tick();
    endtask

    initial
    begin
        int phase, target, k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short window, short timeout
        configure(16'd2, 4'd2, 6'd14, 6'd0);
        send_item(1'b1, -4096, -4096, -4096);   // tick with nothing running
        send_item(1'b0, -500, -1100, -1100);     // active but window closed
        send_item(1'b0, 4095, 4095, 4095);
        send_item(1'b0, 1000, 500, 800);         // downward left opens window
        send_item(1'b0, 500, -200, 350);
        send_item(1'b0, 0, -600, 0);             // glance
        send_item(1'b0, -500, -200, -1100);      // no second trigger
        send_item(1'b1, 0, 0, 0);
        send_item(1'b1, 4095, -1, 1);            // timeout expires
        send_item(1'b1, 0, 0, 0);
        send_item(1'b0, -1000, -500, -800);      // downward right
        send_item(1'b0, -600, 700, -500);        // away with zero window
        send_item(1'b0, 0, -600, 0);
        send_item(1'b0, 0, -600, 0);
        send_item(1'b0, 501, -600, 0);           // just outside active box

        // directed: zero threshold, no timeout, saturated windows
        configure(16'd0, 4'd0, 6'd63, 6'd63);
        send_item(1'b0, 600, 1200, 500);
        send_item(1'b0, 0, -1100, 0);            // glance on first active sample
        send_item(1'b1, 0, 0, 0);
        send_item(1'b0, 800, -500, -800);
        send_item(1'b0, 0, 0, 0);
        send_item(1'b0, 0, -200, 350);
        send_item(1'b0, -800, 500, 800);
        send_item(1'b0, 0, 1201, 0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                configure(16'hFFFF, 4'd15, 6'd62, 6'd0);
            else if (phase == 1)
                configure(16'd1, 4'd1, 6'd0, 6'd62);
            else if (phase == 2)
                configure(16'd0, 4'd0, 6'd63, 6'd63);
            else
                configure(16'($urandom_range(20)), 4'($urandom_range(15)),
                          6'($urandom_range(62)), 6'($urandom_range(62)));

            case (phase % 4)
                0: begin in_idle_pct = 0;  out_stall_pct <= 0;  end
                1: begin in_idle_pct = 83; out_stall_pct <= 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct <= 83; end
                default: begin in_idle_pct = 14; out_stall_pct <= 14; end
            endcase

            if (phase == 0)
            begin
                // fill the block against a held-off receiver, then let it empty
                hold_request <= hold_request + 1;
                repeat (24) send_pose(P_ACTIVE);
                drain();
            end

            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
            begin
                k = $urandom_range(9);
                if (k == 0)
                    send_pose(P_NOISE);
                else if (k == 1)
                    send_pose(P_EDGE);
                else if (k == 2)
                    send_tick();
                else
                    run_gesture();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        $display("ran %0d transactions over %0d register settings and four idle patterns",
                 items_sent, PHASES + 2);
        $display("saw %0d glances and %0d timeouts", glances_seen, timeouts_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
